// ===== hdl/gpm_pkg.sv =====
`default_nettype none

package gpm_pkg;

  // Item kinds on the input channel.
  typedef enum logic [1:0] {
    KIND_TOKEN = 2'd0,
    KIND_CLASS = 2'd1,
    KIND_TEXT  = 2'd2,
    KIND_END   = 2'd3
  } kind_e;

  // Pattern token operations.
  typedef enum logic [1:0] {
    TOK_LIT   = 2'd0,
    TOK_STAR  = 2'd1,
    TOK_ANY   = 2'd2,
    TOK_CLASS = 2'd3
  } tok_e;

  localparam int unsigned ClassWords    = 4;
  localparam int unsigned ClassWordBits = 64;

  // Write control for one token cell.
  typedef struct packed {
    logic        tok_we;
    logic        cls_we;
    tok_e        op;
    logic [7:0]  lit;
    logic [1:0]  word_idx;
    logic [63:0] bits;
  } cell_wr_t;

  // Per-cell status toward the live-set update.
  typedef struct packed {
    logic is_star;
    logic accepts;
  } cell_st_t;

endpackage

`default_nettype wire

// ===== hdl/glob_pattern_matcher_top.sv =====
`default_nettype none

// Channel | Handshake              | Payload
// --------+------------------------+------------------------------------------
// input   | in_valid_i/in_ready_o  | kind, new_pattern, token_op, token_byte,
//         |                        | class_word_index, class_bits, text_byte
// output  | out_valid_o/out_ready_i| matched, pattern_overflow
//
// One item is taken every cycle while the input does not stall; an end-of-text
// result passes through the input register, then the result register.
// Each text byte updates all live positions together through the token
// cell row and the star-closure prefix network.
// Reset is asynchronous and clears control state only; no clearing pass runs.
// The input stalls only while an end-of-text item waits behind a full output
// register that is not being taken.
module glob_pattern_matcher_top #(
  parameter int unsigned MAX_TOKENS = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  kind_i,
  input  wire logic        new_pattern_i,
  input  wire logic [1:0]  token_op_i,
  input  wire logic [7:0]  token_byte_i,
  input  wire logic [1:0]  class_word_index_i,
  input  wire logic [63:0] class_bits_i,
  input  wire logic [7:0]  text_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             matched_o,
  output logic             pattern_overflow_o
);

  localparam int unsigned NumPos = MAX_TOKENS + 1;
  localparam int unsigned CW     = $clog2(MAX_TOKENS + 1);
  localparam int unsigned TW     = (MAX_TOKENS > 1) ? $clog2(MAX_TOKENS) : 1;

  // Input register.
  logic                  s1_valid_q;
  gpm_pkg::kind_e        s1_kind_q;
  logic                  s1_new_q;
  gpm_pkg::tok_e         s1_op_q;
  logic [7:0]            s1_lit_q;
  logic [1:0]            s1_widx_q;
  logic [63:0]           s1_bits_q;
  logic [7:0]            s1_text_q;
  logic                  s1_go;

  // Matcher state.
  logic [CW-1:0]         count_q, count_d;
  logic                  ovf_q, ovf_d;
  logic                  tgt_valid_q, tgt_valid_d;
  logic [TW-1:0]         tgt_q, tgt_d;
  logic [NumPos-1:0]     raw_q, raw_d;

  // Result register.
  logic                  out_valid_q;
  logic                  matched_q;
  logic                  ovf_out_q;

  logic [CW-1:0]         cnt_base;
  logic                  tok_item;
  logic                  tok_store;
  gpm_pkg::cell_wr_t     wr [MAX_TOKENS];
  gpm_pkg::cell_st_t     st [MAX_TOKENS];
  logic [NumPos-1:0]     prop;
  logic [NumPos-1:0]     live;
  logic [NumPos-1:0]     step_raw;

  // Stage advance and input handshake.
  assign s1_go      = s1_valid_q &&
                      ((s1_kind_q != gpm_pkg::KIND_END) || !out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_go;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_kind_q <= gpm_pkg::kind_e'(kind_i);
      s1_new_q  <= new_pattern_i;
      s1_op_q   <= gpm_pkg::tok_e'(token_op_i);
      s1_lit_q  <= token_byte_i;
      s1_widx_q <= class_word_index_i;
      s1_bits_q <= class_bits_i;
      s1_text_q <= text_byte_i;
    end
  end

  // Token append position and capacity check.
  assign tok_item  = s1_go && (s1_kind_q == gpm_pkg::KIND_TOKEN);
  assign cnt_base  = s1_new_q ? '0 : count_q;
  assign tok_store = tok_item && (cnt_base < CW'(MAX_TOKENS));

  // Token cell row.
  for (genvar i = 0; i < MAX_TOKENS; i++) begin : g_cell
    always_comb begin
      wr[i].tok_we   = tok_store && (cnt_base == CW'(i));
      wr[i].cls_we   = s1_go && (s1_kind_q == gpm_pkg::KIND_CLASS) && tgt_valid_q &&
                       (tgt_q == TW'(i));
      wr[i].op       = s1_op_q;
      wr[i].lit      = s1_lit_q;
      wr[i].word_idx = s1_widx_q;
      wr[i].bits     = s1_bits_q;
    end

    gpm_cell u_cell (
      .clk_i  (clk_i),
      .wr_i   (wr[i]),
      .byte_i (s1_text_q),
      .st_o   (st[i])
    );
  end

  // Star propagation enables: position j+1 follows a live star at j.
  always_comb begin
    prop = '0;
    for (int j = 0; j < MAX_TOKENS; j++) begin
      prop[j+1] = st[j].is_star && (CW'(j) < count_q);
    end
  end

  gpm_close #(
    .NumPos (NumPos)
  ) u_close (
    .raw_i    (raw_q),
    .prop_i   (prop),
    .closed_o (live)
  );

  // One text byte: stars hold their position, matching tokens advance.
  always_comb begin
    step_raw = '0;
    for (int j = 0; j < MAX_TOKENS; j++) begin
      if (live[j] && (CW'(j) < count_q)) begin
        if (st[j].is_star) begin
          step_raw[j] = 1'b1;
        end else if (st[j].accepts) begin
          step_raw[j+1] = 1'b1;
        end
      end
    end
  end

  // Next matcher state.
  always_comb begin
    count_d     = count_q;
    ovf_d       = ovf_q;
    tgt_valid_d = tgt_valid_q;
    tgt_d       = tgt_q;
    raw_d       = raw_q;
    if (s1_go) begin
      case (s1_kind_q)
        gpm_pkg::KIND_TOKEN: begin
          ovf_d       = s1_new_q ? 1'b0 : ovf_q;
          tgt_valid_d = s1_new_q ? 1'b0 : tgt_valid_q;
          if (tok_store) begin
            count_d = cnt_base + CW'(1);
            if (s1_op_q == gpm_pkg::TOK_CLASS) begin
              tgt_valid_d = 1'b1;
              tgt_d       = cnt_base[TW-1:0];
            end
          end else begin
            count_d = cnt_base;
            ovf_d   = 1'b1;
            if (s1_op_q == gpm_pkg::TOK_CLASS) begin
              tgt_valid_d = 1'b0;
            end
          end
          raw_d = NumPos'(1);
        end
        gpm_pkg::KIND_TEXT: raw_d = step_raw;
        gpm_pkg::KIND_END:  raw_d = NumPos'(1);
        default:            raw_d = raw_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      ovf_q       <= 1'b0;
      tgt_valid_q <= 1'b0;
      tgt_q       <= '0;
      raw_q       <= NumPos'(1);
    end else begin
      count_q     <= count_d;
      ovf_q       <= ovf_d;
      tgt_valid_q <= tgt_valid_d;
      tgt_q       <= tgt_d;
      raw_q       <= raw_d;
    end
  end

  // Result register, loaded by an end-of-text item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_go && (s1_kind_q == gpm_pkg::KIND_END)) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go && (s1_kind_q == gpm_pkg::KIND_END)) begin
      matched_q <= live[count_q];
      ovf_out_q <= ovf_q;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign matched_o          = matched_q;
  assign pattern_overflow_o = ovf_out_q;

  // The stored pattern never grows past capacity.
  a_count_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_TOKENS))
    else $error("pattern count beyond capacity");

  // Overflow is only flagged with a full pattern.
  a_ovf_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |-> (count_q == CW'(MAX_TOKENS)))
    else $error("overflow flag set with room left");

  // A new result only follows an end-of-text transaction leaving the input stage.
  a_result_src : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s1_go && (s1_kind_q == gpm_pkg::KIND_END)))
    else $error("result without end of text");

  // The input only stalls behind a blocked result.
  a_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (s1_valid_q && out_valid_q && !out_ready_i))
    else $error("input stalled without cause");

  // A class word never lands without a stored class target.
  a_cls_target : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_go && (s1_kind_q == gpm_pkg::KIND_CLASS) && !tgt_valid_q) |=> $stable(tgt_q))
    else $error("class target moved on an ignored class word");

endmodule

`default_nettype wire

// ===== hdl/gpm_cell.sv =====
`default_nettype none

module gpm_cell (
  input  wire logic              clk_i,
  input  wire gpm_pkg::cell_wr_t wr_i,
  input  wire logic [7:0]        byte_i,
  output gpm_pkg::cell_st_t      st_o
);

  gpm_pkg::tok_e type_q;
  logic [7:0]    lit_q;
  logic [gpm_pkg::ClassWordBits-1:0] cls_q [gpm_pkg::ClassWords];

  // Token storage; a new class token starts from an empty set.
  always_ff @(posedge clk_i) begin
    if (wr_i.tok_we) begin
      type_q <= wr_i.op;
      lit_q  <= wr_i.lit;
    end
  end

  for (genvar w = 0; w < gpm_pkg::ClassWords; w++) begin : g_word
    always_ff @(posedge clk_i) begin
      if (wr_i.tok_we && (wr_i.op == gpm_pkg::TOK_CLASS)) begin
        cls_q[w] <= '0;
      end else if (wr_i.cls_we && (wr_i.word_idx == 2'(w))) begin
        cls_q[w] <= wr_i.bits;
      end
    end
  end

  // Byte acceptance for this position.
  always_comb begin
    st_o.is_star = (type_q == gpm_pkg::TOK_STAR);
    case (type_q)
      gpm_pkg::TOK_LIT:   st_o.accepts = (lit_q == byte_i);
      gpm_pkg::TOK_ANY:   st_o.accepts = 1'b1;
      gpm_pkg::TOK_CLASS: st_o.accepts = cls_q[byte_i[7:6]][byte_i[5:0]];
      default:            st_o.accepts = 1'b0;
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/gpm_close.sv =====
`default_nettype none

// Closes a set of positions over star tokens with a parallel prefix network:
// out[j] = raw[j] | (out[j-1] & prop[j]).
module gpm_close #(
  parameter int unsigned NumPos = 33
) (
  input  wire logic [NumPos-1:0] raw_i,
  input  wire logic [NumPos-1:0] prop_i,
  output logic      [NumPos-1:0] closed_o
);

  localparam int unsigned Levels = (NumPos > 1) ? $clog2(NumPos) : 1;

  logic [NumPos-1:0] g [Levels+1];
  logic [NumPos-1:0] p [Levels+1];

  assign g[0] = raw_i;
  assign p[0] = prop_i;

  for (genvar l = 0; l < Levels; l++) begin : g_lvl
    for (genvar j = 0; j < NumPos; j++) begin : g_pos
      if (j >= (1 << l)) begin : g_comb
        assign g[l+1][j] = g[l][j] | (p[l][j] & g[l][j-(1<<l)]);
        assign p[l+1][j] = p[l][j] & p[l][j-(1<<l)];
      end else begin : g_pass
        assign g[l+1][j] = g[l][j];
        assign p[l+1][j] = p[l][j];
      end
    end
  end

  assign closed_o = g[Levels];

endmodule

`default_nettype wire

// ===== tb/glob_pattern_matcher_top_tb.sv =====
`default_nettype none

module glob_pattern_matcher_top_tb;

  localparam int unsigned MaxTokens  = 32;
  localparam int unsigned ItemGoal   = 1300;
  localparam int unsigned CycleLimit = 250000;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned DrainWait  = 10;

  // One input transaction with every payload field.
  typedef struct {
    gpm_pkg::kind_e kind;
    logic           new_pat;
    gpm_pkg::tok_e  op;
    logic [7:0]     tok_byte;
    logic [1:0]     word_idx;
    logic [63:0]    bits;
    logic [7:0]     text;
  } glob_item_t;

  // Verdict that an end-of-text transaction produces.
  typedef struct {
    logic matched;
    logic overflow;
  } verdict_t;

  // Tracks the stored pattern and the live positions, and queues the verdicts.
  class match_scoreboard;
    gpm_pkg::tok_e        tok_kind[MaxTokens];
    logic [7:0]           tok_lit[MaxTokens];
    logic [63:0]          class_word[MaxTokens][4];
    int unsigned          tok_count;
    logic [MaxTokens:0]   live;
    bit                   overflow;
    bit                   class_ok;
    int unsigned          class_slot;
    verdict_t             verdict_q[$];
    int unsigned          failures;

    function new();
      restart();
    endfunction

    // A live star also makes the following position live.
    function logic [MaxTokens:0] close_stars(logic [MaxTokens:0] s);
      for (int i = 0; i < tok_count; i++) begin
        if (s[i] && tok_kind[i] == gpm_pkg::TOK_STAR) s[i + 1] = 1'b1;
      end
      return s;
    endfunction

    function void restart();
      live = '0;
      live[0] = 1'b1;
      live = close_stars(live);
    endfunction

    function bit accepts(int unsigned i, logic [7:0] b);
      case (tok_kind[i])
        gpm_pkg::TOK_LIT:   return tok_lit[i] == b;
        gpm_pkg::TOK_ANY:   return 1'b1;
        gpm_pkg::TOK_CLASS: return class_word[i][b[7:6]][b[5:0]];
        default:            return 1'b0;
      endcase
    endfunction

    function int unsigned pending();
      return verdict_q.size();
    endfunction

    function void flag_failure(string msg);
      if (failures < 10) $display("[%0t] %s", $realtime, msg);
      failures++;
    endfunction

    // Applies one accepted input transaction to the predicted state.
    function void note_item(glob_item_t it);
      logic [MaxTokens:0] nxt;
      verdict_t v;
      case (it.kind)
        gpm_pkg::KIND_TOKEN: begin
          if (it.new_pat) begin
            tok_count = 0;
            overflow = 1'b0;
            class_ok = 1'b0;
          end
          if (tok_count < MaxTokens) begin
            tok_kind[tok_count] = it.op;
            tok_lit[tok_count] = it.tok_byte;
            if (it.op == gpm_pkg::TOK_CLASS) begin
              for (int w = 0; w < 4; w++) class_word[tok_count][w] = '0;
              class_slot = tok_count;
              class_ok = 1'b1;
            end
            tok_count++;
          end else begin
            overflow = 1'b1;
            if (it.op == gpm_pkg::TOK_CLASS) class_ok = 1'b0;
          end
          restart();
        end
        gpm_pkg::KIND_CLASS: begin
          if (class_ok) class_word[class_slot][it.word_idx] = it.bits;
        end
        gpm_pkg::KIND_TEXT: begin
          nxt = '0;
          for (int i = 0; i < tok_count; i++) begin
            if (live[i]) begin
              if (tok_kind[i] == gpm_pkg::TOK_STAR) nxt[i] = 1'b1;
              else if (accepts(i, it.text)) nxt[i + 1] = 1'b1;
            end
          end
          live = close_stars(nxt);
        end
        default: begin
          v.matched = live[tok_count];
          v.overflow = overflow;
          verdict_q.insert(verdict_q.size(), v);
          restart();
        end
      endcase
    endfunction

    // Compares one result transaction with the oldest pending verdict.
    function void check_verdict(logic m, logic o);
      verdict_t want;
      if (verdict_q.size() == 0) begin
        flag_failure($sformatf("unexpected result: matched=%0d overflow=%0d", m, o));
        return;
      end
      want = verdict_q.pop_front();
      if (m !== want.matched || o !== want.overflow) begin
        flag_failure($sformatf("expected matched=%0d overflow=%0d, got matched=%0d overflow=%0d",
                               want.matched, want.overflow, m, o));
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [1:0]  kind_i;
  logic        new_pattern_i;
  logic [1:0]  token_op_i;
  logic [7:0]  token_byte_i;
  logic [1:0]  class_word_index_i;
  logic [63:0] class_bits_i;
  logic [7:0]  text_byte_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic        matched_o;
  logic        pattern_overflow_o;

  match_scoreboard sb;
  int unsigned     send_idle_pct;
  int unsigned     recv_idle_pct;
  int unsigned     items_sent;
  int unsigned     hold_requests;
  int unsigned     holds_served;
  int unsigned     hold_left;
  int unsigned     cycle_count;

  // Pattern copy used only to build texts that have a chance to match.
  gpm_pkg::tok_e gen_op[$];
  logic [7:0]    gen_lit[$];
  logic [255:0]  gen_set[$];

  glob_pattern_matcher_top #(
    .MAX_TOKENS(MaxTokens)
  ) dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .kind_i             (kind_i),
    .new_pattern_i      (new_pattern_i),
    .token_op_i         (token_op_i),
    .token_byte_i       (token_byte_i),
    .class_word_index_i (class_word_index_i),
    .class_bits_i       (class_bits_i),
    .text_byte_i        (text_byte_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .matched_o          (matched_o),
    .pattern_overflow_o (pattern_overflow_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Run limit.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Result side: random stalls, plus a long hold-off when one is requested.
  initial begin
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_left == 0 && hold_requests != holds_served) begin
        hold_left = HoldCycles;
        holds_served++;
      end
      if (hold_left > 0) begin
        out_ready_i = 1'b0;
        hold_left--;
      end else begin
        out_ready_i = ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Every result transaction is checked at the edge that takes it.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_verdict(matched_o, pattern_overflow_o);
  end

  function automatic logic [7:0] pick_byte();
    if ($urandom_range(9) < 8) return 8'($urandom_range(100, 97));
    return 8'($urandom_range(255));
  endfunction

  function automatic glob_item_t noise_item();
    glob_item_t it;
    it.kind = gpm_pkg::kind_e'($urandom_range(3));
    it.new_pat = 1'($urandom_range(1));
    it.op = gpm_pkg::tok_e'($urandom_range(3));
    it.tok_byte = 8'($urandom_range(255));
    it.word_idx = 2'($urandom_range(3));
    it.bits = {$urandom, $urandom};
    it.text = 8'($urandom_range(255));
    return it;
  endfunction

  // Drives one input transaction and waits for the block to take it.
  task automatic send_item(input glob_item_t it);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    kind_i = it.kind;
    new_pattern_i = it.new_pat;
    token_op_i = it.op;
    token_byte_i = it.tok_byte;
    class_word_index_i = it.word_idx;
    class_bits_i = it.bits;
    text_byte_i = it.text;
    do @(posedge clk_i); while (!in_ready_o);
    if (!(it.kind == gpm_pkg::KIND_CLASS && !sb.class_ok)) items_sent++;
    sb.note_item(it);
  endtask

  // Unused fields of each transaction carry random values.
  task automatic put_token(input bit np, input gpm_pkg::tok_e op, input logic [7:0] b);
    glob_item_t it;
    it = noise_item();
    it.kind = gpm_pkg::KIND_TOKEN;
    it.new_pat = np;
    it.op = op;
    it.tok_byte = b;
    send_item(it);
  endtask

  task automatic put_class(input logic [1:0] idx, input logic [63:0] bits);
    glob_item_t it;
    it = noise_item();
    it.kind = gpm_pkg::KIND_CLASS;
    it.word_idx = idx;
    it.bits = bits;
    send_item(it);
  endtask

  task automatic put_text(input logic [7:0] b);
    glob_item_t it;
    it = noise_item();
    it.kind = gpm_pkg::KIND_TEXT;
    it.text = b;
    send_item(it);
  endtask

  task automatic put_end();
    glob_item_t it;
    it = noise_item();
    it.kind = gpm_pkg::KIND_END;
    send_item(it);
  endtask

  // Class sets: a range around the common letters, its complement, one byte or noise.
  function automatic logic [255:0] make_class_set();
    logic [255:0] s;
    int unsigned lo;
    int unsigned hi;
    s = '0;
    lo = $urandom_range(100, 95);
    hi = $urandom_range(104, lo);
    case ($urandom_range(3))
      0: for (int b = lo; b <= hi; b++) s[b] = 1'b1;
      1: for (int w = 0; w < 8; w++) s[w*32 +: 32] = $urandom;
      2: begin
        for (int b = lo; b <= hi; b++) s[b] = 1'b1;
        s = ~s;
      end
      default: s[pick_byte()] = 1'b1;
    endcase
    return s;
  endfunction

  // Loads a fresh pattern of n tokens; class tokens get their words in rotated order.
  task automatic load_pattern(input int unsigned n);
    gpm_pkg::tok_e op;
    logic [7:0] lit;
    logic [255:0] set;
    int unsigned r;
    int unsigned first;
    logic [1:0] idx;
    gen_op.delete();
    gen_lit.delete();
    gen_set.delete();
    for (int unsigned k = 0; k < n; k++) begin
      r = $urandom_range(99);
      if (r < 40) op = gpm_pkg::TOK_LIT;
      else if (r < 60) op = gpm_pkg::TOK_STAR;
      else if (r < 75) op = gpm_pkg::TOK_ANY;
      else op = gpm_pkg::TOK_CLASS;
      lit = pick_byte();
      put_token(k == 0, op, lit);
      set = '0;
      if (op == gpm_pkg::TOK_CLASS) begin
        set = make_class_set();
        first = $urandom_range(3);
        for (int w = 0; w < 4; w++) begin
          idx = 2'(first + w);
          if ($urandom_range(99) < 10) set[idx*64 +: 64] = '0;
          else put_class(idx, set[idx*64 +: 64]);
        end
      end
      if (k < MaxTokens) begin
        gen_op.insert(gen_op.size(), op);
        gen_lit.insert(gen_lit.size(), lit);
        gen_set.insert(gen_set.size(), set);
      end
    end
  endtask

  // Streams a text built from the pattern copy, sometimes damaged, then ends it.
  task automatic run_text();
    logic [7:0] txt[$];
    logic [7:0] b;
    int unsigned pos;
    int unsigned tries;
    for (int k = 0; k < gen_op.size(); k++) begin
      case (gen_op[k])
        gpm_pkg::TOK_LIT:  txt.insert(txt.size(), gen_lit[k]);
        gpm_pkg::TOK_ANY:  txt.insert(txt.size(), pick_byte());
        gpm_pkg::TOK_STAR: repeat ($urandom_range(3)) txt.insert(txt.size(), pick_byte());
        default: begin
          b = pick_byte();
          tries = 0;
          while (!gen_set[k][b] && tries < 24) begin
            b = (tries < 12) ? pick_byte() : 8'($urandom_range(255));
            tries++;
          end
          txt.insert(txt.size(), b);
        end
      endcase
    end
    if ($urandom_range(99) < 30) begin
      pos = $urandom_range(txt.size());
      case ($urandom_range(2))
        0: txt.insert(pos, pick_byte());
        1: if (pos < txt.size()) txt.delete(pos);
        default: if (pos < txt.size()) txt[pos] = pick_byte();
      endcase
    end
    foreach (txt[k]) put_text(txt[k]);
    // Now and then a token lands in the middle of a text and restarts it.
    if ($urandom_range(99) < 4) begin
      b = pick_byte();
      put_token(1'b0, gpm_pkg::TOK_LIT, b);
      if (gen_op.size() < MaxTokens) begin
        gen_op.insert(gen_op.size(), gpm_pkg::TOK_LIT);
        gen_lit.insert(gen_lit.size(), b);
        gen_set.insert(gen_set.size(), '0);
      end
      repeat ($urandom_range(2)) put_text(pick_byte());
    end
    put_end();
  endtask

  initial begin
    int unsigned target;
    int unsigned r;
    int unsigned n;
    sb = new();
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    kind_i = '0;
    new_pattern_i = 1'b0;
    token_op_i = '0;
    token_byte_i = '0;
    class_word_index_i = '0;
    class_bits_i = '0;
    text_byte_i = '0;
    send_idle_pct = 27;
    recv_idle_pct = 67;
    items_sent = 0;
    hold_requests = 0;
    holds_served = 0;
    hold_left = 0;
    cycle_count = 0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Empty pattern: only the empty text matches.
    put_end();
    put_text(8'h00);
    put_end();
    // A class word with no class token to land in is dropped.
    put_class(2'd2, '1);
    // Pattern: 0xFF, star, any byte, class, 0x00. The class words arrive after
    // the last literal and still belong to the class token.
    put_token(1'b1, gpm_pkg::TOK_LIT, 8'hFF);
    put_token(1'b0, gpm_pkg::TOK_STAR, pick_byte());
    put_token(1'b0, gpm_pkg::TOK_ANY, pick_byte());
    put_token(1'b0, gpm_pkg::TOK_CLASS, pick_byte());
    put_token(1'b0, gpm_pkg::TOK_LIT, 8'h00);
    put_class(2'd0, 64'h1);
    put_class(2'd1, 64'h8000_0000_0000_0000);
    put_class(2'd2, '1);
    put_class(2'd3, 64'h8000_0000_0000_0000);
    put_text(8'hFF);
    put_text(8'h7F);
    put_text(8'hFF);
    put_text(8'h00);
    put_end();
    put_text(8'hFF);
    put_text(8'h00);
    put_text(8'h00);
    put_end();
    // Dead text: the first byte already kills every position.
    put_text(8'h01);
    put_end();
    // A token in the middle of a text throws the text away.
    put_text(8'hFF);
    put_token(1'b0, gpm_pkg::TOK_STAR, pick_byte());
    put_end();

    // Capacity: the 33rd token and a dropped class token set the overflow flag.
    load_pattern(MaxTokens + 1);
    put_token(1'b0, gpm_pkg::TOK_CLASS, pick_byte());
    put_class(2'd0, '1);
    run_text();
    run_text();

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 27;
          recv_idle_pct = 67;
        end
        1: begin
          send_idle_pct = 67;
          recv_idle_pct = 27;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      // With results held off, a run of short texts backs up into the input.
      if (phase == 2) begin
        hold_requests++;
        repeat (24) begin
          put_text(pick_byte());
          put_end();
        end
      end
      target = ItemGoal * (phase + 1) / 3;
      while (items_sent < target) begin
        r = $urandom_range(99);
        if (r < 8) begin
          repeat ($urandom_range(4, 1)) send_item(noise_item());
        end else begin
          if (r < 88) n = $urandom_range(8, 1);
          else if (r < 96) n = $urandom_range(31, 9);
          else n = $urandom_range(MaxTokens + 4, MaxTokens);
          load_pattern(n);
          repeat ($urandom_range(5, 2)) run_text();
        end
      end
    end

    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
hdl/gpm_pkg.sv
hdl/gpm_cell.sv
hdl/gpm_close.sv
hdl/glob_pattern_matcher_top.sv
tb/glob_pattern_matcher_top_tb.sv
